>>> hdl/swqm_pkg.sv
// shared types and constants for the semaphore wait queue manager
package swqm_pkg;

  localparam int NUM_PROCS = 32;
  localparam int KEY_BITS  = 32;
  localparam int PROC_BITS = $clog2(NUM_PROCS);
  localparam int CNT_BITS  = $clog2(NUM_PROCS + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_OUT    = 2'd2,
    OP_HEAD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_DESC  = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic load;       // capture input beat
    logic scan_start; // clear scan state
    logic scan_step;  // examine one descriptor
    logic exec;       // apply the operation once the scan is done
    logic walk_start; // begin take-out queue walk
    logic walk_step;  // follow one link
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic walk_needed;
    logic walk_done;
  } stat_t;

endpackage

>>> hdl/swqm_ctrl.sv
// controller state machine sequencing scan, walk and result
module swqm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  swqm_pkg::stat_t    stat,
  output swqm_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_WALK = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.walk_needed) begin
          cmd.walk_start = 1'b1;
          state_nxt = S_WALK;
        end else begin
          cmd.exec = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          cmd.exec = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> hdl/swqm_dp.sv
// datapath: descriptor and process tables, key scan, link walk
module swqm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swqm_pkg::cmd_t                      cmd,
  output swqm_pkg::stat_t                     stat,
  input  logic [1:0]                          in_operation,
  input  logic [31:0]                         in_sem_key,
  input  logic [4:0]                          in_proc_id,
  output logic [1:0]                          out_status,
  output logic [4:0]                          out_result_proc
);

  localparam int NP = swqm_pkg::NUM_PROCS;
  localparam int PB = swqm_pkg::PROC_BITS;
  localparam int KB = swqm_pkg::KEY_BITS;
  localparam int CB = swqm_pkg::CNT_BITS;

  logic [NP-1:0] desc_valid_r;
  logic [NP-1:0] proc_queued_r;
  logic [KB-1:0] desc_key_r   [NP];
  logic [PB-1:0] desc_head_r  [NP];
  logic [PB-1:0] desc_tail_r  [NP];
  logic [PB-1:0] proc_next_r  [NP];
  logic [KB-1:0] proc_key_r   [NP];

  logic [1:0]    op_r;
  logic [KB-1:0] key_r;
  logic [PB-1:0] p_r;
  logic          p_ok_r;
  logic [CB-1:0] scan_r;
  logic          hit_r, free_ok_r;
  logic [PB-1:0] hit_d_r, free_d_r;
  logic [PB-1:0] cur_r, prev_r;
  logic          prev_ok_r, found_r, wdone_r;
  logic [CB-1:0] steps_r;
  logic [1:0]    status_r;
  logic [4:0]    res_r;

  logic [PB-1:0] sidx;
  logic [KB-1:0] skey;
  logic [5:0]    p_wide;

  assign sidx   = scan_r[PB-1:0];
  assign p_wide = {1'b0, in_proc_id};
  // take-out searches by the key the process waits on
  assign skey   = (op_r == swqm_pkg::OP_OUT) ? proc_key_r[p_r] : key_r;

  assign stat.scan_done   = (scan_r == CB'(NP - 1));
  assign stat.walk_needed = (op_r == swqm_pkg::OP_OUT) && p_ok_r
                            && proc_queued_r[p_r] && hit_r;
  assign stat.walk_done   = wdone_r;

  assign out_status      = status_r;
  assign out_result_proc = res_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      key_r  <= KB'(in_sem_key);
      p_r    <= PB'(in_proc_id);
      p_ok_r <= (p_wide < 6'(NP));
    end
    if (cmd.scan_start) begin
      scan_r <= '0;
      hit_r <= 1'b0; free_ok_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!stat.scan_done) scan_r <= scan_r + 1'b1;
      if (!hit_r && desc_valid_r[sidx] && desc_key_r[sidx] == skey) begin
        hit_r <= 1'b1; hit_d_r <= sidx;
      end
      if (!free_ok_r && !desc_valid_r[sidx]) begin
        free_ok_r <= 1'b1; free_d_r <= sidx;
      end
    end
    if (cmd.walk_start) begin
      cur_r <= desc_head_r[hit_d_r];
      prev_ok_r <= 1'b0; found_r <= 1'b0; wdone_r <= 1'b0; steps_r <= '0;
    end else if (cmd.walk_step) begin
      if (cur_r == p_r) begin
        found_r <= 1'b1; wdone_r <= 1'b1;
      end else if (cur_r == desc_tail_r[hit_d_r] || steps_r == CB'(NP - 1)) begin
        wdone_r <= 1'b1;
      end else begin
        prev_r <= cur_r; prev_ok_r <= 1'b1;
        cur_r <= proc_next_r[cur_r];
        steps_r <= steps_r + 1'b1;
      end
    end
  end

  // table updates on exec
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= swqm_pkg::ST_NOTFOUND;
      res_r <= '0;
      case (op_r)
        swqm_pkg::OP_INSERT: begin
          if (p_ok_r && !proc_queued_r[p_r]) begin
            if (hit_r) begin
              proc_next_r[desc_tail_r[hit_d_r]] <= p_r;
              desc_tail_r[hit_d_r] <= p_r;
            end else if (free_ok_r) begin
              desc_key_r[free_d_r]  <= key_r;
              desc_head_r[free_d_r] <= p_r;
              desc_tail_r[free_d_r] <= p_r;
            end
            if (hit_r || free_ok_r) begin
              status_r <= swqm_pkg::ST_DONE;
              proc_key_r[p_r] <= key_r;
              if (!(hit_r && desc_tail_r[hit_d_r] == p_r)) proc_next_r[p_r] <= '0;
            end else begin
              status_r <= swqm_pkg::ST_NO_DESC;
            end
          end
        end
        swqm_pkg::OP_REMOVE: begin
          if (hit_r) begin
            if (desc_head_r[hit_d_r] != desc_tail_r[hit_d_r])
              desc_head_r[hit_d_r] <= proc_next_r[desc_head_r[hit_d_r]];
            status_r <= swqm_pkg::ST_DONE;
            res_r <= 5'(desc_head_r[hit_d_r]);
          end
        end
        swqm_pkg::OP_OUT: begin
          if (found_r && stat.walk_needed) begin
            if (!prev_ok_r) begin
              if (desc_tail_r[hit_d_r] != p_r)
                desc_head_r[hit_d_r] <= proc_next_r[p_r];
            end else begin
              proc_next_r[prev_r] <= proc_next_r[p_r];
              if (desc_tail_r[hit_d_r] == p_r) desc_tail_r[hit_d_r] <= prev_r;
            end
            status_r <= swqm_pkg::ST_DONE;
            res_r <= 5'(p_r);
          end
        end
        swqm_pkg::OP_HEAD: begin
          if (hit_r) begin
            status_r <= swqm_pkg::ST_DONE;
            res_r <= 5'(desc_head_r[hit_d_r]);
          end
        end
        default: ;
      endcase
    end
  end

  // valid bits with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r  <= '0;
      proc_queued_r <= '0;
    end else if (cmd.exec) begin
      case (op_r)
        swqm_pkg::OP_INSERT: begin
          if (p_ok_r && !proc_queued_r[p_r] && (hit_r || free_ok_r)) begin
            proc_queued_r[p_r] <= 1'b1;
            if (!hit_r) desc_valid_r[free_d_r] <= 1'b1;
          end
        end
        swqm_pkg::OP_REMOVE: begin
          if (hit_r) begin
            proc_queued_r[desc_head_r[hit_d_r]] <= 1'b0;
            if (desc_head_r[hit_d_r] == desc_tail_r[hit_d_r])
              desc_valid_r[hit_d_r] <= 1'b0;
          end
        end
        swqm_pkg::OP_OUT: begin
          if (found_r && stat.walk_needed) begin
            proc_queued_r[p_r] <= 1'b0;
            if (desc_head_r[hit_d_r] == p_r && desc_tail_r[hit_d_r] == p_r)
              desc_valid_r[hit_d_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/semaphore_wait_queue_manager.sv
// semaphore wait queue manager top level
// insert, remove and peek: a key scan over all 32 descriptors, then exec and result
// take-out adds a link walk through the matching queue before exec when one is needed
// a new beat is taken only in idle, after the previous result has been accepted
// reset: synchronous active-low rst_n frees all descriptors and unblocks all processes
module semaphore_wait_queue_manager (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [31:0] in_sem_key,
  input  logic [4:0] in_proc_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [4:0] out_result_proc
);

  swqm_pkg::cmd_t  cmd;
  swqm_pkg::stat_t stat;

  swqm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  swqm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_operation(in_operation), .in_sem_key(in_sem_key), .in_proc_id(in_proc_id),
    .out_status(out_status), .out_result_proc(out_result_proc)
  );

  // no new beat taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted with result pending");

  // result appears only after an exec command
  a_exec_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.exec)) else $error("result without exec");

  // status is one of the defined codes when shown
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status code");

endmodule
